// ===== rtl/modexp_pkg.sv =====
package modexp_pkg;

	localparam int WIDTH = 64;
	localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// controls shared by every cell of the chain
	typedef struct packed {
		logic load_mul;
		logic shift_mul;
		logic load_exp;
		logic shift_exp;
	} cell_ctl_t;

endpackage

// ===== rtl/modexp_cell.sv =====
module modexp_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  modexp_pkg::cell_ctl_t ctl,
	input  logic                  mul_load,
	input  logic                  exp_load,
	input  logic                  mul_in,
	input  logic                  exp_in,
	output logic                  mul_out,
	output logic                  exp_out
);

	logic mul_q;
	logic exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q <= 1'b0;
			exp_q <= 1'b0;
		end else begin
			if (ctl.load_mul) begin
				mul_q <= mul_load;
			end else if (ctl.shift_mul) begin
				mul_q <= mul_in;
			end
			if (ctl.load_exp) begin
				exp_q <= exp_load;
			end else if (ctl.shift_exp) begin
				exp_q <= exp_in;
			end
		end
	end

	assign mul_out = mul_q;
	assign exp_out = exp_q;

endmodule

// ===== rtl/modular_exponentiation_core.sv =====
// Channel  Dir  Payload
// s_*      in   tdata: base[63:0], exponent[127:64], modulus[191:128]
// m_*      out  tdata: power_mod[63:0]; tuser: status
//
// One item at a time. The item is accepted, then each exponent bit costs a
// square, plus a multiply where the bit is set, in the bit-serial modular
// multiplier; the result is then handed to the output register. A zero
// modulus skips the multiplier.
// A new item is taken while the last result still waits at the output;
// the core stalls at its end until the output register is free.
module modular_exponentiation_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // base, exponent, modulus
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // power_mod
	output logic         m_tuser    // status
);

	localparam int W = modexp_pkg::WIDTH;
	localparam int CW = modexp_pkg::CNT_W;

	modexp_pkg::state_t state_q, state_d;
	modexp_pkg::cell_ctl_t ctl;

	logic [W-1:0] m_q, b_q, acc_q, p_q, x_q;
	logic [W-1:0] mul_load, exp_load, mul_bits, exp_bits;
	logic [CW-1:0] cyc_q, ebit_q;
	logic phase_q;
	logic out_free, accept, mul_end, do_mult, item_end;
	logic [W:0] dbl, dbl_r, sum, sum_r;
	logic [W-1:0] p_next;
	logic [63:0] pm_q;
	logic st_q, vld_q;

	assign out_free = !vld_q || m_tready;
	assign s_tready = (state_q == modexp_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// chain of cells: multiplier bits and exponent bits shift toward the top
	for (genvar i = 0; i < W; i++) begin : g_cell
		modexp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.mul_load(mul_load[i]),
			.exp_load(exp_load[i]),
			.mul_in  ((i == 0) ? 1'b0 : mul_bits[(i == 0) ? 0 : i-1]),
			.exp_in  ((i == 0) ? 1'b0 : exp_bits[(i == 0) ? 0 : i-1]),
			.mul_out (mul_bits[i]),
			.exp_out (exp_bits[i])
		);
	end

	// double, then add the addend where the multiplier bit is set
	always_comb begin
		dbl   = {p_q, 1'b0};
		dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		sum   = dbl_r + {1'b0, x_q};
		sum_r = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
		p_next = mul_bits[W-1] ? sum_r[W-1:0] : dbl_r[W-1:0];
	end

	assign mul_end  = (state_q == modexp_pkg::ST_RUN) && (cyc_q == CW'(W-1));
	assign do_mult  = !phase_q && exp_bits[W-1];
	assign item_end = mul_end && !do_mult && (ebit_q == CW'(W-1));

	always_comb begin
		state_d = state_q;
		ctl = '0;
		exp_load = s_tdata[64 +: W];
		mul_load = p_next;
		case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (accept) begin
					ctl.load_exp = 1'b1;
					ctl.load_mul = 1'b1;
					mul_load = (s_tdata[128 +: W] == W'(1)) ? '0 : W'(1);
					state_d = (s_tdata[128 +: W] == '0) ? modexp_pkg::ST_DONE
					                                    : modexp_pkg::ST_RUN;
				end
			end
			modexp_pkg::ST_RUN: begin
				ctl.shift_mul = 1'b1;
				if (mul_end) begin
					ctl.load_mul = 1'b1;
					mul_load = do_mult ? b_q : p_next;
					ctl.shift_exp = !do_mult;
					if (item_end) begin
						state_d = modexp_pkg::ST_DONE;
					end
				end
			end
			modexp_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = modexp_pkg::ST_IDLE;
				end
			end
			default: state_d = modexp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= modexp_pkg::ST_IDLE;
			cyc_q   <= '0;
			ebit_q  <= '0;
			phase_q <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == modexp_pkg::ST_DONE && out_free) begin
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
			if (accept) begin
				cyc_q   <= '0;
				ebit_q  <= '0;
				phase_q <= 1'b0;
			end else if (state_q == modexp_pkg::ST_RUN) begin
				if (mul_end) begin
					cyc_q   <= '0;
					phase_q <= do_mult;
					if (!do_mult) begin
						ebit_q <= ebit_q + CW'(1);
					end
				end else begin
					cyc_q <= cyc_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b_q   <= s_tdata[0 +: W];
			m_q   <= s_tdata[128 +: W];
			acc_q <= (s_tdata[128 +: W] == W'(1)) ? '0 : W'(1);
			x_q   <= (s_tdata[128 +: W] == W'(1)) ? '0 : W'(1);
			p_q   <= '0;
		end else if (state_q == modexp_pkg::ST_RUN) begin
			if (mul_end) begin
				// next operation: square, or multiply by base; addend is the new value
				acc_q <= p_next;
				x_q   <= p_next;
				p_q   <= '0;
			end else begin
				p_q <= p_next;
			end
		end
		if (state_q == modexp_pkg::ST_DONE && out_free) begin
			pm_q <= (m_q == '0) ? 64'd0 : 64'(acc_q);
			st_q <= (m_q == '0);
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = pm_q;
	assign m_tuser  = st_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic [63:0] base;
		logic [63:0] exponent;
		logic [63:0] modulus;
		bit          known;
		logic [63:0] power_mod;
		logic        status;
	} vector_t;

	typedef struct {
		logic [63:0] power_mod;
		logic        status;
	} result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic         m_tuser;

	result_t pending_q[$];
	int      mismatches = 0;
	bit      stim_done = 0;
	bit      hold_off = 0;
	bit      hold_start = 0;
	bit      calm = 0;

	vector_t directed[$];

	modular_exponentiation_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	// a + b mod m without leaving WIDTH bits; a, b < m
	function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [63:0] room;
		room = m - b;
		return (a >= room) ? a - room : a + b;
	endfunction

	function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [63:0] ar;
		logic [63:0] acc;
		ar = a % m;
		acc = '0;
		for (int i = modexp_pkg::WIDTH - 1; i >= 0; i--) begin
			acc = add_mod(acc, acc, m);
			if (b[i])
				acc = add_mod(acc, ar, m);
		end
		return acc;
	endfunction

	function automatic result_t power_mod_of(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		result_t r;
		logic [63:0] acc;
		if (m == 0) begin
			r.power_mod = '0;
			r.status = 1'b1;
			return r;
		end
		acc = 64'd1 % m;
		for (int i = modexp_pkg::WIDTH - 1; i >= 0; i--) begin
			acc = mul_mod(acc, acc, m);
			if (e[i])
				acc = mul_mod(acc, b, m);
		end
		r.power_mod = acc;
		r.status = 1'b0;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic add_row(logic [63:0] b, logic [63:0] e, logic [63:0] m, bit known,
			logic [63:0] p, logic s);
		vector_t v;
		v.base = b; v.exponent = e; v.modulus = m;
		v.known = known; v.power_mod = p; v.status = s;
		directed.push_back(v);
	endtask

	task automatic send_item(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		while (!calm && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {m, e, b};
		do @(posedge clk); while (!s_tready);
	endtask

	// receiver: random stalls, plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
	end

	// long hold-off of the receiver, counted in cycles
	initial begin
		int waited;
		wait (hold_start);
		@(posedge clk);
		hold_off <= 1'b1;
		waited = 0;
		while (waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: power_mod=%h status=%b", m_tdata, m_tuser);
			end else begin
				want = pending_q.pop_front();
				if (m_tdata !== want.power_mod || m_tuser !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%b, got %h/%b",
							want.power_mod, want.status, m_tdata, m_tuser);
				end
			end
		end
	end

	// sender side: expectation queued when the input item is accepted
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			pending_q.push_back(power_mod_of(s_tdata[63:0], s_tdata[127:64], s_tdata[191:128]));
	end

	initial begin
		add_row(64'd5, 64'd0, 64'd7, 1, 64'd1, 1'b0);
		add_row(64'd5, 64'd0, 64'd1, 1, 64'd0, 1'b0);
		add_row(64'd9, 64'd3, 64'd1, 1, 64'd0, 1'b0);
		add_row(64'd9, 64'd3, 64'd0, 1, 64'd0, 1'b1);
		add_row('1, '1, 64'd0, 1, 64'd0, 1'b1);
		add_row(64'd0, 64'd5, 64'd13, 1, 64'd0, 1'b0);
		add_row(64'd2, 64'd10, 64'd1000, 1, 64'd24, 1'b0);
		add_row(64'd3, 64'd4, 64'd100, 1, 64'd81, 1'b0);
		add_row('1, '1, '1, 1, 64'd0, 1'b0);
		add_row('1, '1, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 0);
		add_row(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '1, 0, 0, 0);
		add_row(64'd12345, 64'd1, 64'd7, 0, 0, 0);
		add_row(64'hDEAD_BEEF_0123_4567, 64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFC5, 0, 0, 0);
		add_row(64'h1234_5678_9ABC_DEF0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0001, 0, 0, 0);
		add_row(64'd7, 64'd1, 64'd2, 1, 64'd1, 1'b0);
		add_row(64'd0, 64'd0, 64'd0, 1, 64'd0, 1'b1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			result_t p;
			p = power_mod_of(directed[i].base, directed[i].exponent, directed[i].modulus);
			if (directed[i].known && (p.power_mod !== directed[i].power_mod
					|| p.status !== directed[i].status)) begin
				mismatches++;
				$display("table row %0d disagrees with prediction", i);
			end
			send_item(directed[i].base, directed[i].exponent, directed[i].modulus);
		end

		// hold the output back while items keep coming so the core stalls
		hold_start <= 1'b1;
		for (int i = 0; i < 100; i++) begin
			logic [63:0] b, e, m;
			calm <= (i >= 40 && i < 60);
			b = rand64();
			e = rand64();
			case ($urandom_range(9))
				0: m = '0;
				1: m = 64'd1;
				2: m = {32'd0, $urandom};
				3: m = '1 - $urandom_range(255);
				default: m = rand64();
			endcase
			if ($urandom_range(7) == 0)
				e = e >> $urandom_range(63);
			send_item(b, e, m);
		end
		s_tvalid <= 1'b0;
		calm <= 1'b0;

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("[modular_exponentiation_core] OK");
		else
			$display("[modular_exponentiation_core] ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("[modular_exponentiation_core] ERROR");
		$finish;
	end

endmodule
